// File: rtl/mrld_pkg.sv
// types and constants of the mask run-length decoder
package mrld_pkg;

	localparam logic [7:0] MAGIC_BYTE = 8'h55;
	localparam logic [7:0] BLACK_VALUE = 8'h00;
	localparam logic [7:0] WHITE_VALUE = 8'hFF;

	localparam int COUNT_W = 28;
	localparam int ACC_W = 24;

	// chunk type codes in header bits 7:6
	typedef enum logic [1:0] {
		KIND_BLACK = 2'b00,
		KIND_GREY  = 2'b01,
		KIND_BAD   = 2'b10,
		KIND_WHITE = 2'b11
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_MAGIC = 3'd1,
		ST_CHECK = 3'd2,
		ST_TYPE  = 3'd3,
		ST_TRUNC = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		PH_MAGIC   = 5'b00001,
		PH_HEADER  = 5'b00010,
		PH_GREY    = 5'b00100,
		PH_EXT     = 5'b01000,
		PH_DISCARD = 5'b10000
	} phase_t;

	typedef struct packed {
		logic               is_report;
		logic [7:0]         run_value;
		logic [COUNT_W-1:0] run_count;
		status_t            status;
	} result_t;

endpackage

// File: rtl/mask_run_length_decoder.sv
// mask run-length decoder: frame parser with registered result and skid stage
//
// channel   direction  handshake                    payload
// byte      request in byte_valid / byte_ready      byte_in, frame_end
// result    request out result_valid / result_ready is_report, run_value, run_count, status
//
// one byte request is taken per cycle while byte_ready is high; parser state is written
// at the accepting edge, any run or report into the result register or the skid stage
// the combinational header/grey/extension parser sets the rate: one byte per ready clock
// the skid register absorbs one result while the result register stalls, so
// byte_ready only drops when both hold a result
// arst_n clears parser state and both valid flags; the next byte is taken as magic
module mask_run_length_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  byte_in,
	input  logic        frame_end,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        is_report,
	output logic [7:0]  run_value,
	output logic [27:0] run_count,
	output logic [2:0]  status
);

	// parser state
	mrld_pkg::phase_t                phase_q;
	mrld_pkg::kind_t                 kind_q;
	logic [3:0]                      nibble_q;
	logic [1:0]                      ext_left_q;
	logic [mrld_pkg::ACC_W-1:0]      acc_q;
	logic [7:0]                      held_q;
	logic [7:0]                      sum_q;
	mrld_pkg::status_t               error_q;

	mrld_pkg::phase_t                phase_d;
	mrld_pkg::kind_t                 kind_d;
	logic [3:0]                      nibble_d;
	logic [1:0]                      ext_left_d;
	logic [mrld_pkg::ACC_W-1:0]      acc_d;
	logic [7:0]                      held_d;
	logic [7:0]                      sum_d;
	mrld_pkg::status_t               error_d;

	// result produced by the byte on the port
	logic                            res_valid;
	mrld_pkg::result_t               res;

	// output register and skid stage
	logic                            out_valid_q;
	logic                            skid_valid_q;
	mrld_pkg::result_t               out_q;
	mrld_pkg::result_t               skid_q;

	logic                            accept;
	logic                            acc_res;
	logic                            take;
	logic                            out_free;
	logic                            load_out;
	logic                            load_skid;

	assign accept   = byte_valid && byte_ready;
	assign acc_res  = accept && res_valid;
	assign take     = result_valid && result_ready;
	assign out_free = take || !out_valid_q;
	assign load_out = out_free && (skid_valid_q || acc_res);
	assign load_skid = acc_res && !out_free;

	assign byte_ready   = !skid_valid_q;
	assign result_valid = out_valid_q;
	assign is_report    = out_q.is_report;
	assign run_value    = out_q.run_value;
	assign run_count    = out_q.run_count;
	assign status       = out_q.status;

	// parser next state and result
	always_comb begin
		logic [mrld_pkg::COUNT_W-1:0] len;
		mrld_pkg::kind_t              kind_in;
		logic                         finish;

		phase_d    = phase_q;
		kind_d     = kind_q;
		nibble_d   = nibble_q;
		ext_left_d = ext_left_q;
		acc_d      = acc_q;
		held_d     = held_q;
		sum_d      = sum_q;
		error_d    = error_q;
		res_valid  = 1'b0;
		res        = '0;
		finish     = 1'b0;
		kind_in    = mrld_pkg::kind_t'(byte_in[7:6]);
		len        = '0;

		if (frame_end) begin
			// checksum byte: report and return to reset values
			res_valid     = 1'b1;
			res.is_report = 1'b1;
			if (phase_q == mrld_pkg::PH_MAGIC) begin
				res.status = mrld_pkg::ST_TRUNC;
			end else if (error_q == mrld_pkg::ST_MAGIC) begin
				res.status = mrld_pkg::ST_MAGIC;
			end else if (byte_in != ~sum_q) begin
				res.status = mrld_pkg::ST_CHECK;
			end else if (error_q == mrld_pkg::ST_TYPE) begin
				res.status = mrld_pkg::ST_TYPE;
			end else if (phase_q inside {mrld_pkg::PH_GREY, mrld_pkg::PH_EXT}) begin
				res.status = mrld_pkg::ST_TRUNC;
			end else begin
				res.status = mrld_pkg::ST_OK;
			end
			phase_d    = mrld_pkg::PH_MAGIC;
			kind_d     = mrld_pkg::KIND_BLACK;
			nibble_d   = '0;
			ext_left_d = '0;
			acc_d      = '0;
			held_d     = '0;
			sum_d      = '0;
			error_d    = mrld_pkg::ST_OK;
		end else if (phase_q == mrld_pkg::PH_MAGIC) begin
			if (byte_in == mrld_pkg::MAGIC_BYTE) begin
				phase_d = mrld_pkg::PH_HEADER;
			end else begin
				error_d = mrld_pkg::ST_MAGIC;
				phase_d = mrld_pkg::PH_DISCARD;
			end
		end else if (error_q != mrld_pkg::ST_MAGIC) begin
			sum_d = sum_q + byte_in;
			case (phase_q)
				mrld_pkg::PH_HEADER: begin
					nibble_d   = byte_in[3:0];
					ext_left_d = byte_in[5:4];
					kind_d     = kind_in;
					acc_d      = '0;
					case (kind_in)
						mrld_pkg::KIND_BAD: begin
							error_d = mrld_pkg::ST_TYPE;
							phase_d = mrld_pkg::PH_DISCARD;
						end
						mrld_pkg::KIND_GREY: begin
							phase_d = mrld_pkg::PH_GREY;
						end
						default: begin
							held_d = (kind_in == mrld_pkg::KIND_WHITE) ?
								mrld_pkg::WHITE_VALUE : mrld_pkg::BLACK_VALUE;
							if (byte_in[5:4] != 2'd0) begin
								phase_d = mrld_pkg::PH_EXT;
							end else begin
								finish = 1'b1;
							end
						end
					endcase
				end
				mrld_pkg::PH_GREY: begin
					held_d = byte_in;
					if (ext_left_q != 2'd0) begin
						phase_d = mrld_pkg::PH_EXT;
					end else begin
						finish = 1'b1;
					end
				end
				mrld_pkg::PH_EXT: begin
					acc_d      = {acc_q[mrld_pkg::ACC_W-9:0], byte_in};
					ext_left_d = ext_left_q - 2'd1;
					if (ext_left_q == 2'd1) begin
						finish = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		// close the chunk; zero-length runs give nothing
		if (finish) begin
			phase_d       = mrld_pkg::PH_HEADER;
			len           = {acc_d, nibble_d};
			res.is_report = 1'b0;
			res.run_value = held_d;
			res.run_count = len;
			res.status    = mrld_pkg::ST_OK;
			res_valid     = (len != '0);
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= mrld_pkg::PH_MAGIC;
			kind_q     <= mrld_pkg::KIND_BLACK;
			nibble_q   <= '0;
			ext_left_q <= '0;
			acc_q      <= '0;
			held_q     <= '0;
			sum_q      <= '0;
			error_q    <= mrld_pkg::ST_OK;
		end else if (accept) begin
			phase_q    <= phase_d;
			kind_q     <= kind_d;
			nibble_q   <= nibble_d;
			ext_left_q <= ext_left_d;
			acc_q      <= acc_d;
			held_q     <= held_d;
			sum_q      <= sum_d;
			error_q    <= error_d;
		end
	end

	// valid flags of result register and skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= skid_valid_q || acc_res;
			end
			if (load_skid) begin
				skid_valid_q <= 1'b1;
			end else if (out_free) begin
				skid_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_valid_q ? skid_q : res;
		end
		if (load_skid) begin
			skid_q <= res;
		end
	end

	// the skid stage only fills behind a stalled result register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds a result while the result register is empty");

	// a run never carries a status and never has zero length
	a_run_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.is_report) |->
			(out_q.status == mrld_pkg::ST_OK && out_q.run_count != '0))
		else $error("malformed run result");

	// the checksum byte always sends the parser back to the magic phase and clears the sum
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && frame_end) |=> (phase_q == mrld_pkg::PH_MAGIC && sum_q == '0))
		else $error("parser did not restart after frame end");

	// a bad magic byte parks the parser until frame end
	a_magic_discard: assert property (@(posedge clk) disable iff (!arst_n)
		(error_q == mrld_pkg::ST_MAGIC) |-> (phase_q == mrld_pkg::PH_DISCARD))
		else $error("bad magic frame left the discard phase");

endmodule
